// File: rtl/core/indexed_list_engine_top_assert.svh
// ----------------------------------------------------------------------------
// indexed_list_engine_top_assert.svh
// Assertion macros used by the list engine datapath.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
`define INDEXED_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTH
`define ILE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("list engine assertion failed");
`define ILE_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("list engine forbidden condition");
`else
`define ILE_ASSERT(lbl, prop)
`define ILE_ASSERT_NEVER(lbl, expr)
`endif
`endif

// File: rtl/core/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Types and codes for the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam logic [2:0] CMD_READ      = 3'd0;
	localparam logic [2:0] CMD_INS_FRONT = 3'd1;
	localparam logic [2:0] CMD_INS_BACK  = 3'd2;
	localparam logic [2:0] CMD_INS_POS   = 3'd3;
	localparam logic [2:0] CMD_DELETE    = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [15:0] position;
		logic signed [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [10:0]        length;
	} out_word_t;

	typedef enum logic [2:0] {
		DEC_READ   = 3'd0,
		DEC_INSERT = 3'd1,
		DEC_DELETE = 3'd2,
		DEC_RANGE  = 3'd3,
		DEC_FULL   = 3'd4
	} dec_t;

	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_LOAD     = 4'd1,
		OP_CHECK    = 4'd2,
		OP_RD_SLOT  = 4'd3,
		OP_GET_SLOT = 4'd4,
		OP_SH_RD    = 4'd5,
		OP_SH_WR    = 4'd6,
		OP_PLACE    = 4'd7,
		OP_RD_ELEM  = 4'd8,
		OP_RESULT   = 4'd9
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		dec_t dec_now;
		dec_t dec;
		logic use_free;
		logic shift_more;
	} dp_stat_t;

endpackage

// File: rtl/core/ile_datapath.sv
// ----------------------------------------------------------------------------
// ile_datapath
// Item registers, link and value memories, length and slot counters.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_top_assert.svh"

module ile_datapath #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ile_pkg::dp_cmd_t  cmd,
	input  ile_pkg::in_word_t in_word,
	output ile_pkg::dp_stat_t stat,
	output ile_pkg::out_word_t out_word
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic [2:0]         cmd_q;
	logic signed [15:0] pos_q;
	logic [31:0]        val_q;
	ile_pkg::dec_t      dec_q;
	ile_pkg::dec_t      dec_now;
	logic [LW-1:0]      len_q;
	logic [LW-1:0]      hw_q;
	logic [LW-1:0]      idx_q;
	logic [LW-1:0]      target_q;
	logic [AW-1:0]      slot_q;
	logic [AW-1:0]      link_rd_q;
	logic [31:0]        elem_rd_q;
	ile_pkg::out_word_t out_q;

	logic [AW-1:0] link_mem [CAPACITY];
	logic [31:0]   elem_mem [CAPACITY];

	logic [31:0]   pos32;
	logic [31:0]   len32;
	logic          pos_lt_len;
	logic          pos_le_len;
	logic          full;
	logic [LW-1:0] target_now;
	logic          is_ins;
	logic [LW-1:0] idx_nx;
	logic [LW-1:0] idx_pv;
	logic          link_re;
	logic [LW-1:0] link_raddr;
	logic          link_we;
	logic [LW-1:0] link_waddr;
	logic [AW-1:0] link_wdata;

	assign pos32      = {17'd0, pos_q[14:0]};
	assign len32      = 32'(len_q);
	assign pos_lt_len = !pos_q[15] && (pos32 < len32);
	assign pos_le_len = !pos_q[15] && (pos32 <= len32);
	assign full       = (len32 == 32'(CAPACITY));
	assign is_ins     = (dec_q == ile_pkg::DEC_INSERT);
	assign idx_nx     = idx_q + LW'(1);
	assign idx_pv     = idx_q - LW'(1);

	always_comb begin
		dec_now    = ile_pkg::DEC_RANGE;
		target_now = pos32[LW-1:0];
		case (cmd_q)
			ile_pkg::CMD_READ: begin
				dec_now = pos_lt_len ? ile_pkg::DEC_READ : ile_pkg::DEC_RANGE;
			end
			ile_pkg::CMD_INS_FRONT: begin
				dec_now    = full ? ile_pkg::DEC_FULL : ile_pkg::DEC_INSERT;
				target_now = '0;
			end
			ile_pkg::CMD_INS_BACK: begin
				dec_now    = full ? ile_pkg::DEC_FULL : ile_pkg::DEC_INSERT;
				target_now = len_q;
			end
			ile_pkg::CMD_INS_POS: begin
				if (!pos_le_len) dec_now = ile_pkg::DEC_RANGE;
				else dec_now = full ? ile_pkg::DEC_FULL : ile_pkg::DEC_INSERT;
			end
			ile_pkg::CMD_DELETE: begin
				dec_now = pos_lt_len ? ile_pkg::DEC_DELETE : ile_pkg::DEC_RANGE;
			end
			default: begin
				dec_now = ile_pkg::DEC_RANGE;
			end
		endcase
	end

	always_comb begin
		link_re    = 1'b0;
		link_raddr = target_q;
		link_we    = 1'b0;
		link_waddr = idx_q;
		link_wdata = link_rd_q;
		case (cmd.op)
			ile_pkg::OP_RD_SLOT: begin
				link_re    = 1'b1;
				link_raddr = is_ins ? len_q : target_q;
			end
			ile_pkg::OP_SH_RD: begin
				link_re    = 1'b1;
				link_raddr = is_ins ? idx_pv : idx_nx;
			end
			ile_pkg::OP_SH_WR: begin
				link_we = 1'b1;
			end
			ile_pkg::OP_PLACE: begin
				link_we    = 1'b1;
				link_waddr = is_ins ? target_q : (len_q - LW'(1));
				link_wdata = slot_q;
			end
			default: begin
				link_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (link_re) link_rd_q <= link_mem[link_raddr[AW-1:0]];
		if (link_we) link_mem[link_waddr[AW-1:0]] <= link_wdata;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ile_pkg::OP_RD_ELEM) elem_rd_q <= elem_mem[slot_q];
		if (cmd.op == ile_pkg::OP_PLACE && is_ins) elem_mem[slot_q] <= val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			hw_q  <= '0;
			dec_q <= ile_pkg::DEC_RANGE;
		end else begin
			case (cmd.op)
				ile_pkg::OP_CHECK: begin
					dec_q <= dec_now;
					if (dec_now == ile_pkg::DEC_INSERT && len_q == hw_q) begin
						hw_q <= hw_q + LW'(1);
					end
				end
				ile_pkg::OP_PLACE: begin
					len_q <= is_ins ? len_q + LW'(1) : len_q - LW'(1);
				end
				default: begin
					len_q <= len_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			ile_pkg::OP_LOAD: begin
				cmd_q <= in_word.command;
				pos_q <= in_word.position;
				val_q <= in_word.value;
			end
			ile_pkg::OP_CHECK: begin
				target_q <= target_now;
				idx_q    <= (dec_now == ile_pkg::DEC_INSERT) ? len_q : target_now;
				slot_q   <= hw_q[AW-1:0];
			end
			ile_pkg::OP_GET_SLOT: begin
				slot_q <= link_rd_q;
			end
			ile_pkg::OP_SH_WR: begin
				idx_q <= is_ins ? idx_pv : idx_nx;
			end
			ile_pkg::OP_RESULT: begin
				out_q.length <= len32[10:0];
				if (dec_q == ile_pkg::DEC_READ) out_q.read_value <= elem_rd_q;
				else if (cmd_q == ile_pkg::CMD_READ) out_q.read_value <= -32'sd1;
				else out_q.read_value <= '0;
				if (dec_q == ile_pkg::DEC_RANGE) out_q.status <= ile_pkg::ST_RANGE;
				else if (dec_q == ile_pkg::DEC_FULL) out_q.status <= ile_pkg::ST_FULL;
				else out_q.status <= ile_pkg::ST_DONE;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign stat.dec_now    = dec_now;
	assign stat.dec        = dec_q;
	assign stat.use_free   = (len_q != hw_q);
	assign stat.shift_more = is_ins ? (idx_q != target_q) : (idx_nx != len_q);
	assign out_word        = out_q;

	`ILE_ASSERT(len_cap_a, 32'(len_q) <= 32'(CAPACITY))
	`ILE_ASSERT(hw_above_len_a, hw_q >= len_q)
	`ILE_ASSERT_NEVER(place_full_a, cmd.op == ile_pkg::OP_PLACE && is_ins && full)

endmodule

// File: rtl/core/ile_ctrl.sv
// ----------------------------------------------------------------------------
// ile_ctrl
// Sequencer for the list engine: decode, slot fetch, link shift, result.
// ----------------------------------------------------------------------------
module ile_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ile_pkg::dp_stat_t stat,
	output ile_pkg::dp_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_CHECK    = 9'b000000010,
		S_RD_SLOT  = 9'b000000100,
		S_GET_SLOT = 9'b000001000,
		S_SH_RD    = 9'b000010000,
		S_SH_WR    = 9'b000100000,
		S_PLACE    = 9'b001000000,
		S_RD_ELEM  = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd.op  = ile_pkg::OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = ile_pkg::OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.op = ile_pkg::OP_CHECK;
				case (stat.dec_now)
					ile_pkg::DEC_READ, ile_pkg::DEC_DELETE: state_d = S_RD_SLOT;
					ile_pkg::DEC_INSERT: state_d = stat.use_free ? S_RD_SLOT : S_SH_RD;
					default: state_d = S_DONE;
				endcase
			end
			S_RD_SLOT: begin
				cmd.op  = ile_pkg::OP_RD_SLOT;
				state_d = S_GET_SLOT;
			end
			S_GET_SLOT: begin
				cmd.op  = ile_pkg::OP_GET_SLOT;
				state_d = (stat.dec == ile_pkg::DEC_READ) ? S_RD_ELEM : S_SH_RD;
			end
			S_SH_RD: begin
				if (stat.shift_more) begin
					cmd.op  = ile_pkg::OP_SH_RD;
					state_d = S_SH_WR;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_SH_WR: begin
				cmd.op  = ile_pkg::OP_SH_WR;
				state_d = S_SH_RD;
			end
			S_PLACE: begin
				cmd.op  = ile_pkg::OP_PLACE;
				state_d = S_DONE;
			end
			S_RD_ELEM: begin
				cmd.op  = ile_pkg::OP_RD_ELEM;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = ile_pkg::OP_RESULT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == ile_pkg::OP_RESULT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: rtl/core/indexed_list_engine_top.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_top
// Bounded ordered list of signed 32-bit values addressed by position.
//
// Input channel in_valid/in_stall/in_word carries a command word: read,
// insert front, insert back, insert at position or delete at position.
// Every accepted word gives exactly one result word on out_valid/out_stall/
// out_word: value read (-1 on a miss), status and the new length.
// One word is processed at a time; in_stall is high while it is at work.
// Rejected commands go from the check straight to the result. Reads fetch
// the slot and then the element. Deletes, and inserts that reuse a freed
// slot, fetch the slot first; inserts and deletes shift list entries one at
// a time through the link memory, a read and then a write for each entry.
// The result sits in an output register; a stalled receiver holds it, and
// the next word may be accepted meanwhile, its result waiting for the slot.
// Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_list_engine_top #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ile_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output ile_pkg::out_word_t out_word
);

	ile_pkg::dp_cmd_t  cmd;
	ile_pkg::dp_stat_t stat;

	ile_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ile_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (in_word),
		.stat     (stat),
		.out_word (out_word)
	);

endmodule
